// ===== rtl/ktt_pkg.sv =====
// ktt_pkg: shared types and constants for the keyed track table.
// No dependencies; used by the slot cell and the top level.
`timescale 1ns / 1ps
package ktt_pkg;
    typedef enum logic [3:0] {
        ACT_FIND = 4'd0, ACT_SEEN = 4'd1, ACT_ALT = 4'd2, ACT_AGE = 4'd3,
        ACT_READ = 4'd4, ACT_COUNT = 4'd5, ACT_SSET = 4'd6, ACT_SGET = 4'd7,
        ACT_NEXT = 4'd8, ACT_PREV = 4'd9, ACT_SIDX = 4'd10, ACT_SICAO = 4'd11
    } t_action;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_GATE    = 1'b1;

    localparam logic signed [17:0] ALT_LIMIT = 18'sd32000;
    localparam int TIME_W = 62;
    localparam int KEY_W  = 24;

    // per-cell command broadcast to all slot cells during a walk step or the write step
    typedef struct packed {
        logic                 claim;
        logic                 seen;
        logic                 good;
        logic                 push;
        logic                 age;
        logic [KEY_W-1:0]     key;
        logic [TIME_W-1:0]    now;
        logic signed [15:0]   alt;
        logic [31:0]          timeout;
        logic [31:0]          gate;
    } t_cell_cmd;

    typedef struct packed {
        logic                 active;
        logic [KEY_W-1:0]     key;
        logic                 ann_ev;
        logic                 lost_ev;
    } t_cell_stat;
endpackage

// ===== rtl/ktt_cell.sv =====
// ktt_cell: one slot of the track table with its altitude ring.
// Depends on ktt_pkg.
`timescale 1ns / 1ps
module ktt_cell #(
    parameter int HISTORY = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sel,
    input  ktt_pkg::t_cell_cmd  i_cmd,
    input  logic [$clog2(HISTORY > 1 ? HISTORY : 2)-1:0] i_pick,
    output ktt_pkg::t_cell_stat o_stat,
    output logic signed [15:0]  o_alt
);
    import ktt_pkg::*;
    localparam int HW = $clog2(HISTORY > 1 ? HISTORY : 2);

    logic              r_active, r_ann;
    logic [KEY_W-1:0]  r_key;
    logic [7:0]        r_good;
    logic [TIME_W-1:0] r_first, r_last;
    logic [HW-1:0]     r_head;
    logic signed [15:0] r_ring [HISTORY];
    logic signed [TIME_W:0] w_age_f, w_age_l;
    logic              w_ann, w_lost;

    assign w_age_f = $signed({1'b0, i_cmd.now}) - $signed({1'b0, r_first});
    assign w_age_l = $signed({1'b0, i_cmd.now}) - $signed({1'b0, r_last});
    // 62-bit times: difference never overflows as a 63-bit signed value
    assign w_ann  = r_active && !r_ann && (r_good != 8'd0) &&
                    (w_age_f > $signed({31'd0, i_cmd.gate}));
    assign w_lost = r_active && (w_age_l > $signed({31'd0, i_cmd.timeout}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ann    <= 1'b0;
            r_key    <= '0;
            r_good   <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_head   <= '0;
            for (int i = 0; i < HISTORY; i++) r_ring[i] <= '0;
        end else if (i_sel) begin
            if (i_cmd.claim) begin
                r_active <= 1'b1;
                r_ann    <= 1'b0;
                r_key    <= i_cmd.key;
                r_good   <= '0;
                r_first  <= i_cmd.now;
                r_last   <= '0;
                r_head   <= '0;
                for (int i = 0; i < HISTORY; i++) r_ring[i] <= -16'sd1;
            end
            if (i_cmd.seen) begin
                r_last <= i_cmd.now;
                if (i_cmd.good && r_good != 8'hFF) r_good <= r_good + 8'd1;
            end
            if (i_cmd.push) begin
                r_ring[r_head] <= i_cmd.alt;
                r_head <= (r_head == HW'(HISTORY - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_cmd.age) begin
                if (w_ann)  r_ann <= 1'b1;
                if (w_lost) r_active <= 1'b0;
            end
        end
    end

    assign o_stat.active  = r_active;
    assign o_stat.key     = r_key;
    assign o_stat.ann_ev  = w_ann;
    assign o_stat.lost_ev = w_lost;
    assign o_alt = r_ring[i_pick];
endmodule

// ===== rtl/keyed_track_table_with_aging.sv =====
// Keyed track table with aging, built on ktt_pkg and a row of ktt_cell slots. A sequencer
// walks the slot cells one per clock. Every command word keeps busy high through a walk
// over all SLOTS slots, one more walk step, a write step and a result step; next and
// prev make a second walk over all slots in place of the one extra walk step. Aging
// results come out during the walk, in the cycle after their slot is visited; the
// closing result, with last_flag set, shows in the same cycle that busy falls.
// The receiver cannot stall: each result shows for one cycle on o_res_valid.
`timescale 1ns / 1ps
module keyed_track_table_with_aging #(
    parameter int SLOTS   = 16,
    parameter int HISTORY = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [3:0]         i_action,
    input  logic [23:0]        i_key_icao,
    input  logic [5:0]         i_slot_number,
    input  logic [61:0]        i_now_time,
    input  logic signed [17:0] i_altitude_feet,
    input  logic               i_good_message,
    input  logic [5:0]         i_history_pick,
    output logic               o_res_valid,
    output logic [1:0]         o_status_code,
    output logic [5:0]         o_slot_out,
    output logic [23:0]        o_icao_out,
    output logic               o_created_flag,
    output logic               o_lost_flag,
    output logic               o_announce_flag,
    output logic               o_active_flag,
    output logic signed [15:0] o_altitude_out,
    output logic signed [6:0]  o_position,
    output logic [6:0]         o_total_active,
    output logic               o_last_flag
);
    import ktt_pkg::*;
    localparam int SW = $clog2(SLOTS > 1 ? SLOTS : 2);
    localparam int HW = $clog2(HISTORY > 1 ? HISTORY : 2);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_WALK = 5'b00010, S_WALK2 = 5'b00100,
        S_DO = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [31:0] r_timeout, r_gate;
    logic [3:0]  r_act;
    logic [23:0] r_key, r_sel;
    logic [5:0]  r_slot, r_pick;
    logic [61:0] r_now;
    logic signed [17:0] r_alt;
    logic r_good;
    logic [SW:0] r_i;           // walk counter
    // walk scratch
    logic r_hit, r_empty_f, r_sel_f, r_first_f, r_after_f, r_last_f;
    logic [SW-1:0] r_hit_i, r_empty_i, r_sel_i, r_first_i, r_after_i, r_lastb_i, r_before_i;
    logic r_before_f;
    logic [6:0] r_tot, r_pos;

    // result register
    logic r_v, r_lst, r_cr, r_lo, r_an, r_ac;
    logic [1:0] r_st;
    logic [5:0] r_so;
    logic [23:0] r_ic;
    logic signed [15:0] r_ao;
    logic signed [6:0] r_po;
    logic [6:0] r_to;

    // closing result and selection update
    logic n_cr, n_ac;
    logic [1:0] n_st;
    logic [5:0] n_so;
    logic [23:0] n_ic, n_sel;
    logic signed [15:0] n_ao;
    logic signed [6:0] n_po;
    logic [6:0] n_to;

    t_cell_cmd  w_cmd;
    t_cell_stat w_stat [SLOTS];
    logic signed [15:0] w_alt [SLOTS];
    logic [SLOTS-1:0] w_sel;
    logic [SW-1:0] w_ci;
    logic w_slot_ok, w_claim, w_seen, w_push, w_age;
    logic signed [15:0] w_clamp;
    t_cell_stat w_cur;
    t_cell_stat w_ds;

    assign w_ci = r_i[SW-1:0];
    assign w_cur = w_stat[w_ci];
    assign w_ds  = w_stat[r_slot[SW-1:0]];
    assign w_slot_ok = ({1'b0, r_slot} < 7'(SLOTS));

    always_comb begin
        if (r_alt > ALT_LIMIT) w_clamp = 16'sd32000;
        else if (r_alt < -ALT_LIMIT) w_clamp = -16'sd32000;
        else w_clamp = r_alt[15:0];
    end

    // aging updates in S_WALK; other writes in S_DO, only to a free or valid active slot
    assign w_age   = (r_state == S_WALK) && (t_action'(r_act) == ACT_AGE);
    assign w_claim = (r_state == S_DO) && (t_action'(r_act) == ACT_FIND) &&
                     !r_hit && r_empty_f;
    assign w_seen  = (r_state == S_DO) && (t_action'(r_act) == ACT_SEEN) &&
                     w_slot_ok && w_ds.active;
    assign w_push  = (r_state == S_DO) && (t_action'(r_act) == ACT_ALT) &&
                     w_slot_ok && w_ds.active;

    always_comb begin
        w_cmd.claim   = w_claim;
        w_cmd.seen    = w_seen;
        w_cmd.good    = r_good;
        w_cmd.push    = w_push;
        w_cmd.age     = w_age;
        w_cmd.key     = r_key;
        w_cmd.now     = r_now;
        w_cmd.alt     = w_clamp;
        w_cmd.timeout = r_timeout;
        w_cmd.gate    = r_gate;
        for (int i = 0; i < SLOTS; i++) begin
            w_sel[i] = (w_age && w_ci == SW'(i)) ||
                       (w_claim && r_empty_i == SW'(i)) ||
                       ((w_seen || w_push) && r_slot[SW-1:0] == SW'(i));
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ktt_cell #(.HISTORY(HISTORY)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sel(w_sel[g]), .i_cmd(w_cmd),
            .i_pick(r_pick[HW-1:0]), .o_stat(w_stat[g]), .o_alt(w_alt[g])
        );
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    logic w_match, w_sm;
    assign w_match = w_cur.active && w_cur.key == r_key;
    assign w_sm = w_cur.active && r_sel != 24'd0 && w_cur.key == r_sel;

    always_comb begin
        n_st = ST_OK; n_so = '0; n_ic = '0; n_cr = 1'b0; n_ac = 1'b0; n_ao = '0;
        n_po = -7'sd1; n_to = '0; n_sel = r_sel;
        case (t_action'(r_act))
            ACT_FIND: begin
                if (r_hit) begin n_so = 6'(r_hit_i); n_ic = r_key; end
                else if (r_empty_f) begin
                    n_so = 6'(r_empty_i); n_ic = r_key; n_cr = 1'b1;
                end else n_st = ST_FULL;
            end
            ACT_SEEN, ACT_ALT: begin
                if (!w_slot_ok) n_st = ST_BAD;
                else begin
                    n_so = r_slot;
                    if (!w_ds.active) n_st = ST_NONE;
                    else n_ic = w_ds.key;
                end
            end
            ACT_READ: begin
                if (!w_slot_ok || {1'b0, r_pick} >= 7'(HISTORY)) n_st = ST_BAD;
                else begin
                    n_so = r_slot; n_ic = w_ds.key;
                    n_ac = w_ds.active; n_ao = w_alt[r_slot[SW-1:0]];
                end
            end
            ACT_COUNT: n_to = r_tot;
            ACT_SSET: begin n_sel = r_key; n_ic = r_key; end
            ACT_SGET: begin
                if (r_sel_f) begin n_so = 6'(r_sel_i); n_ic = r_sel; end
                else if (r_first_f) begin
                    n_so = 6'(r_first_i); n_ic = w_stat[r_first_i].key;
                    n_sel = w_stat[r_first_i].key;
                end else n_st = ST_NONE;
            end
            ACT_NEXT: begin
                if (!r_first_f) begin n_st = ST_NONE; n_sel = '0; end
                else if (r_sel_f && r_after_f) begin
                    n_so = 6'(r_after_i); n_ic = w_stat[r_after_i].key;
                    n_sel = w_stat[r_after_i].key;
                end else begin
                    n_so = 6'(r_first_i); n_ic = w_stat[r_first_i].key;
                    n_sel = w_stat[r_first_i].key;
                end
            end
            ACT_PREV: begin
                if (!r_last_f) begin n_st = ST_NONE; n_sel = '0; end
                else if (r_sel_f && r_before_f) begin
                    n_so = 6'(r_before_i); n_ic = w_stat[r_before_i].key;
                    n_sel = w_stat[r_before_i].key;
                end else begin
                    n_so = 6'(r_lastb_i); n_ic = w_stat[r_lastb_i].key;
                    n_sel = w_stat[r_lastb_i].key;
                end
            end
            ACT_SIDX: begin
                n_to = r_tot;
                if (r_sel_f) begin
                    n_po = r_pos; n_so = 6'(r_sel_i); n_ic = r_sel;
                end else n_st = ST_NONE;
            end
            ACT_SICAO: begin
                if (r_sel_f) begin n_so = 6'(r_sel_i); n_ic = r_sel; end
                else begin n_st = ST_NONE; n_sel = '0; end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_timeout <= 32'd60000000;
            r_gate <= 32'd10000000;
            r_sel <= '0;
            r_v <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GATE) r_gate <= i_cfg_data;
                else r_timeout <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_v <= 1'b0;
                    if (start) begin
                        r_act <= i_action; r_key <= i_key_icao; r_slot <= i_slot_number;
                        r_now <= i_now_time; r_alt <= i_altitude_feet;
                        r_good <= i_good_message; r_pick <= i_history_pick;
                        r_i <= '0;
                        r_hit <= 1'b0; r_empty_f <= 1'b0; r_sel_f <= 1'b0;
                        r_first_f <= 1'b0; r_after_f <= 1'b0; r_last_f <= 1'b0;
                        r_before_f <= 1'b0; r_tot <= '0; r_pos <= 7'h7F;
                        r_hit_i <= '0; r_empty_i <= '0; r_sel_i <= '0; r_first_i <= '0;
                        r_after_i <= '0; r_lastb_i <= '0; r_before_i <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // pass one: gather everything in slot order
                    if (w_match && !r_hit) begin r_hit <= 1'b1; r_hit_i <= w_ci; end
                    if (!w_cur.active && !r_empty_f) begin
                        r_empty_f <= 1'b1; r_empty_i <= w_ci;
                    end
                    if (w_sm && !r_sel_f) begin
                        r_sel_f <= 1'b1; r_sel_i <= w_ci;
                        r_pos <= r_tot;
                    end
                    if (w_cur.active) begin
                        r_tot <= r_tot + 7'd1;
                        if (!r_first_f) begin r_first_f <= 1'b1; r_first_i <= w_ci; end
                        r_last_f <= 1'b1; r_lastb_i <= w_ci;
                    end
                    r_v <= w_age && (w_cur.ann_ev || w_cur.lost_ev);
                    if (w_age && (w_cur.ann_ev || w_cur.lost_ev)) begin
                        r_lst <= 1'b0; r_st <= ST_OK;
                        r_so <= 6'(w_ci); r_ic <= w_cur.key;
                        r_cr <= 1'b0; r_lo <= w_cur.lost_ev; r_an <= w_cur.ann_ev;
                        r_ac <= 1'b0; r_ao <= '0; r_po <= -7'sd1; r_to <= '0;
                        if (w_cur.lost_ev && r_sel == w_cur.key) r_sel <= '0;
                    end
                    if (r_i == (SW+1)'(SLOTS - 1)) begin
                        r_i <= '0;
                        r_state <= S_WALK2;
                    end else r_i <= r_i + 1'b1;
                end
                S_WALK2: begin
                    // pass two: neighbors of the selection, for next/prev
                    r_v <= 1'b0;
                    if (w_cur.active && r_sel_f) begin
                        if (w_ci > r_sel_i && !r_after_f) begin
                            r_after_f <= 1'b1; r_after_i <= w_ci;
                        end
                        if (w_ci < r_sel_i) begin r_before_f <= 1'b1; r_before_i <= w_ci; end
                    end
                    if (r_i == (SW+1)'(SLOTS - 1) ||
                        !(t_action'(r_act) == ACT_NEXT || t_action'(r_act) == ACT_PREV))
                        r_state <= S_DO;
                    else r_i <= r_i + 1'b1;
                end
                S_DO: begin
                    r_v <= 1'b0;
                    r_state <= S_OUT;
                end
                default: begin // S_OUT
                    r_state <= S_IDLE;
                    r_v <= 1'b1; r_lst <= 1'b1;
                    r_st <= n_st; r_so <= n_so; r_ic <= n_ic; r_cr <= n_cr; r_lo <= 1'b0;
                    r_an <= 1'b0; r_ac <= n_ac; r_ao <= n_ao; r_po <= n_po; r_to <= n_to;
                    r_sel <= n_sel;
                end
            endcase
        end
    end

    assign o_res_valid = r_v;
    assign o_status_code = r_st;
    assign o_slot_out = r_so;
    assign o_icao_out = r_ic;
    assign o_created_flag = r_cr;
    assign o_lost_flag = r_lo;
    assign o_announce_flag = r_an;
    assign o_active_flag = r_ac;
    assign o_altitude_out = r_ao;
    assign o_position = r_po;
    assign o_total_active = r_to;
    assign o_last_flag = r_lst;
endmodule
